/* rtl/core/pdi_pkg.sv */
`timescale 1ns / 1ps

package pdi_pkg;

    // Field widths
    localparam int VALUE_W   = 13;
    localparam int FACTOR_W  = 22;
    localparam int SLOPE_W   = 12;
    localparam int OFFSET_W  = VALUE_W + 1;
    localparam int PRODUCT_W = OFFSET_W + SLOPE_W;
    localparam int SUM_W     = PRODUCT_W + 2;

    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic        [FACTOR_W-1:0] factor_t;
    typedef logic signed [SLOPE_W-1:0]  slope_t;

    typedef enum logic [1:0] {
        OP_VOLTAGE     = 2'd0,
        OP_TEMPERATURE = 2'd1,
        OP_PROCESS     = 2'd2
    } op_t;

    localparam factor_t FACTOR_MAX = {FACTOR_W{1'b1}};

    // Voltage table: millivolts, factors in Q2.20, slopes in Q2.20 per mV.
    localparam int VOLT_N     = 7;
    localparam int VOLT_SEG_W = $clog2(VOLT_N - 1);
    localparam value_t VOLT_X [VOLT_N] = '{
        13'sd1080, 13'sd1120, 13'sd1160, 13'sd1200, 13'sd1240, 13'sd1280, 13'sd1320
    };
    localparam factor_t VOLT_Y [VOLT_N] = '{
        22'd1176038, 22'd1127567, 22'd1085445, 22'd1048576,
        22'd1015525, 22'd985730, 22'd958904
    };
    localparam slope_t VOLT_SLOPE [VOLT_N-1] = '{
        -12'sd1212, -12'sd1053, -12'sd922, -12'sd826, -12'sd745, -12'sd671
    };

    // Temperature table: 1/16 degree C, slopes in Q2.20 per LSB.
    localparam int TEMP_N     = 15;
    localparam int TEMP_SEG_W = $clog2(TEMP_N - 1);
    localparam value_t TEMP_X [TEMP_N] = '{
        -13'sd400, -13'sd240, 13'sd0, 13'sd240, 13'sd400, 13'sd560, 13'sd720,
        13'sd880, 13'sd1040, 13'sd1200, 13'sd1360, 13'sd1520, 13'sd1680,
        13'sd1840, 13'sd2000
    };
    localparam factor_t TEMP_Y [TEMP_N] = '{
        22'd941095, 22'd962102, 22'd994404, 22'd1026779, 22'd1048576,
        22'd1069867, 22'd1091085, 22'd1113411, 22'd1135590, 22'd1157436,
        22'd1178729, 22'd1199828, 22'd1221133, 22'd1241902, 22'd1263498
    };
    localparam slope_t TEMP_SLOPE [TEMP_N-1] = '{
        12'sd131, 12'sd135, 12'sd135, 12'sd136, 12'sd133, 12'sd133, 12'sd140,
        12'sd139, 12'sd137, 12'sd133, 12'sd132, 12'sd133, 12'sd130, 12'sd135
    };

    // Process corners 1, 2 and 3.
    localparam factor_t PROC_Y_1 = 22'd1231275;
    localparam factor_t PROC_Y_2 = 22'd1048576;
    localparam factor_t PROC_Y_3 = 22'd918708;

    // Segment chosen for one transaction, plus which factor it updates.
    typedef struct packed {
        logic    accepted;
        logic    upd_voltage;
        logic    upd_temperature;
        logic    upd_process;
        factor_t y1;
        slope_t  slope;
        value_t  x1;
    } seg_sel_t;

endpackage

/* rtl/core/pdi_seg_sel.sv */
`timescale 1ns / 1ps

module pdi_seg_sel
    import pdi_pkg::*;
(
    input  op_t      operation,
    input  value_t   value,
    output seg_sel_t sel
);

    logic [VOLT_SEG_W-1:0] volt_seg;
    logic [TEMP_SEG_W-1:0] temp_seg;

    // Segment index is the number of inner breakpoints at or below the value,
    // so values outside the table fall on the first or last segment.
    always_comb begin
        volt_seg = '0;
        for (int i = 1; i < VOLT_N - 1; i++) begin
            if (value >= VOLT_X[i]) begin
                volt_seg = volt_seg + VOLT_SEG_W'(1);
            end
        end
    end

    always_comb begin
        temp_seg = '0;
        for (int i = 1; i < TEMP_N - 1; i++) begin
            if (value >= TEMP_X[i]) begin
                temp_seg = temp_seg + TEMP_SEG_W'(1);
            end
        end
    end

    // A value exactly on the last breakpoint takes the table value itself,
    // which the rounded last-segment slope would not reproduce. Slope zero
    // with x1 equal to the value yields y1 unchanged.
    always_comb begin
        sel = '0;
        sel.x1 = value;
        unique case (operation)
            OP_VOLTAGE: begin
                sel.accepted    = 1'b1;
                sel.upd_voltage = 1'b1;
                if (value == VOLT_X[VOLT_N-1]) begin
                    sel.y1 = VOLT_Y[VOLT_N-1];
                end else begin
                    sel.y1    = VOLT_Y[volt_seg];
                    sel.slope = VOLT_SLOPE[volt_seg];
                    sel.x1    = VOLT_X[volt_seg];
                end
            end
            OP_TEMPERATURE: begin
                sel.accepted        = 1'b1;
                sel.upd_temperature = 1'b1;
                if (value == TEMP_X[TEMP_N-1]) begin
                    sel.y1 = TEMP_Y[TEMP_N-1];
                end else begin
                    sel.y1    = TEMP_Y[temp_seg];
                    sel.slope = TEMP_SLOPE[temp_seg];
                    sel.x1    = TEMP_X[temp_seg];
                end
            end
            OP_PROCESS: begin
                if (value == 13'sd1) begin
                    sel.accepted    = 1'b1;
                    sel.upd_process = 1'b1;
                    sel.y1          = PROC_Y_1;
                end else if (value == 13'sd2) begin
                    sel.accepted    = 1'b1;
                    sel.upd_process = 1'b1;
                    sel.y1          = PROC_Y_2;
                end else if (value == 13'sd3) begin
                    sel.accepted    = 1'b1;
                    sel.upd_process = 1'b1;
                    sel.y1          = PROC_Y_3;
                end
            end
            default: begin
                sel.accepted = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/pdi_interp.sv */
`timescale 1ns / 1ps

module pdi_interp
    import pdi_pkg::*;
(
    input  seg_sel_t sel,
    input  value_t   value,
    output factor_t  factor
);

    logic signed [OFFSET_W-1:0]  offset;
    logic signed [PRODUCT_W-1:0] product;
    logic signed [SUM_W-1:0]     sum;

    always_comb begin
        offset  = OFFSET_W'(value) - OFFSET_W'(sel.x1);
        product = PRODUCT_W'(offset) * PRODUCT_W'(sel.slope);
        sum     = $signed({{(SUM_W - FACTOR_W){1'b0}}, sel.y1}) + SUM_W'(product);

        // Clamp to the unsigned Q2.20 range.
        if (sum < 0) begin
            factor = '0;
        end else if (sum > $signed({{(SUM_W - FACTOR_W){1'b0}}, FACTOR_MAX})) begin
            factor = FACTOR_MAX;
        end else begin
            factor = sum[FACTOR_W-1:0];
        end
    end

endmodule

/* rtl/core/pvt_derating_interpolator_top.sv */
`timescale 1ns / 1ps

// Channel | Ports                                    | Direction | Transaction
// s_      | s_valid s_ready s_operation s_value      | in        | one lookup request
// m_      | m_valid m_ready m_*_factor m_accepted    | out       | held factors and flag
//
// Each transaction waits in the input register and then moves to the result register,
// and a new transaction is taken every cycle unless a stall on m_ready holds the result;
// the single segment select, multiply and clamp path lies between the two registers.
// The synchronous active-low reset empties both registers and clears all three
// factors to zero. A stall on m_ready holds the result and lets one more
// transaction wait in the input register before s_ready drops.

module pvt_derating_interpolator_top
    import pdi_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_operation,
    input  value_t        s_value,

    output logic          m_valid,
    input  logic          m_ready,
    output factor_t       m_voltage_factor,
    output factor_t       m_temperature_factor,
    output factor_t       m_process_factor,
    output logic          m_accepted
);

    // Input register.
    logic       in_valid_reg;
    logic [1:0] in_op_reg;
    value_t     in_value_reg;

    // Result register. The factor registers are also the block's state: they
    // only change when a transaction moves into the result register, so the
    // reported factors always equal the held ones.
    logic    m_valid_reg;
    logic    m_valid_next;
    logic    accepted_reg;
    factor_t voltage_factor_reg;
    factor_t temperature_factor_reg;
    factor_t process_factor_reg;

    logic     advance;
    seg_sel_t sel;
    factor_t  new_factor;

    // The input register moves forward whenever the result register is empty or
    // its current transaction is being taken this cycle.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    pdi_seg_sel u_seg_sel (
        .operation (op_t'(in_op_reg)),
        .value     (in_value_reg),
        .sel       (sel)
    );

    pdi_interp u_interp (
        .sel    (sel),
        .value  (in_value_reg),
        .factor (new_factor)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg    <= s_operation;
            in_value_reg <= s_value;
        end
    end

    always_comb begin
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg            <= 1'b0;
            voltage_factor_reg     <= '0;
            temperature_factor_reg <= '0;
            process_factor_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance && sel.upd_voltage) begin
                voltage_factor_reg <= new_factor;
            end
            if (advance && sel.upd_temperature) begin
                temperature_factor_reg <= new_factor;
            end
            if (advance && sel.upd_process) begin
                process_factor_reg <= new_factor;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            accepted_reg <= sel.accepted;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_voltage_factor     = voltage_factor_reg;
    assign m_temperature_factor = temperature_factor_reg;
    assign m_process_factor     = process_factor_reg;
    assign m_accepted           = accepted_reg;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for pvt_derating_interpolator_top.
//
// Every transaction accepted on the s_ channel is run through a local model of the three
// breakpoint tables. The model updates its own copy of the held factors, and the reading
// it predicts is queued. Each transaction that leaves on the m_ channel is compared,
// field by field, with the oldest reading in that queue.
//
// The stimulus opens with a directed pass over the tables. That pass covers the
// breakpoints, values below and above each table, the saturation limits, every process
// corner, invalid corners and the unused operation code. Random traffic follows, in three
// phases of back-pressure: sender sparse and receiver choked, the reverse, and both sides
// at full rate. One burst test stops the sender until every outstanding result has been
// drained.

module tb_top;
    import pdi_pkg::*;

    // The operation field is two bits wide, but the package names only three codes.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int VOLT_PTS      = 7;
    localparam int TEMP_PTS      = 15;
    localparam int CORNER_PTS    = 3;
    localparam int SETTLE_CYCLES = 10;

    // Breakpoint tables. Factors are given in millionths and converted to Q2.20 on use.
    localparam int VOLT_MV [VOLT_PTS] = '{1080, 1120, 1160, 1200, 1240, 1280, 1320};
    localparam int VOLT_PPM [VOLT_PTS] = '{
        1121557, 1075332, 1035161, 1000000, 968480, 940065, 914482
    };
    localparam int TEMP_LSB [TEMP_PTS] = '{
        -400, -240, 0, 240, 400, 560, 720, 880, 1040, 1200, 1360, 1520, 1680, 1840, 2000
    };
    localparam int TEMP_PPM [TEMP_PTS] = '{
        897498, 917532, 948338, 979213, 1000000, 1020305, 1040540, 1061831,
        1082983, 1103817, 1124124, 1144245, 1164563, 1184370, 1204966
    };
    localparam int CORNER_PPM [CORNER_PTS] = '{1174235, 1000000, 876148};

    typedef struct {
        factor_t voltage;
        factor_t temperature;
        factor_t process;
        logic    ok;
    } derating_reading_t;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;

    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [1:0] s_operation = OP_VOLTAGE;
    value_t     s_value     = '0;

    logic    m_valid;
    logic    m_ready = 1'b0;
    factor_t m_voltage_factor;
    factor_t m_temperature_factor;
    factor_t m_process_factor;
    logic    m_accepted;

    // These are the model's copies of the three factor registers. They change only when
    // a transaction is accepted.
    factor_t held_voltage     = '0;
    factor_t held_temperature = '0;
    factor_t held_process     = '0;

    derating_reading_t pending_readings [$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    pvt_derating_interpolator_top uut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_operation          (s_operation),
        .s_value              (s_value),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_voltage_factor     (m_voltage_factor),
        .m_temperature_factor (m_temperature_factor),
        .m_process_factor     (m_process_factor),
        .m_accepted           (m_accepted)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Model of the lookup
    // ------------------------------------------------------------------

    // Converts millionths to Q2.20, rounding half up.
    function automatic longint ppm_to_q20(input longint ppm);
        return (ppm * 1048576 + 500000) / 1000000;
    endfunction

    // This function handles both interpolated tables. A value that lands on a breakpoint
    // returns that breakpoint's factor exactly. A value outside the table runs along the
    // nearest end segment. Each segment's slope is the rise over the run of the Q2.20
    // factors, rounded half away from zero. The interpolated result is then clamped to
    // the range of an unsigned Q2.20 factor.
    function automatic factor_t interpolate(input bit is_temp, input int v);
        longint xs [TEMP_PTS];
        longint ys [TEMP_PTS];
        int     n;
        int     seg;
        longint dx;
        longint dy;
        longint slope;
        longint r;
        n = is_temp ? TEMP_PTS : VOLT_PTS;
        for (int i = 0; i < n; i++) begin
            if (is_temp) begin
                xs[i] = longint'(TEMP_LSB[i]);
                ys[i] = ppm_to_q20(longint'(TEMP_PPM[i]));
            end else begin
                xs[i] = longint'(VOLT_MV[i]);
                ys[i] = ppm_to_q20(longint'(VOLT_PPM[i]));
            end
        end
        seg = 0;
        for (int i = 0; i < n; i++) begin
            if (xs[i] == v)
                return factor_t'(ys[i]);
            if (xs[i] <= v)
                seg = i;
        end
        if (seg > n - 2)
            seg = n - 2;
        dx = xs[seg + 1] - xs[seg];
        dy = ys[seg + 1] - ys[seg];
        if (dy >= 0)
            slope = (dy + dx / 2) / dx;
        else
            slope = -((-dy + dx / 2) / dx);
        r = ys[seg] + slope * (longint'(v) - xs[seg]);
        if (r < 0)
            r = 0;
        if (r > longint'(FACTOR_MAX))
            r = longint'(FACTOR_MAX);
        return factor_t'(r);
    endfunction

    // Applies one accepted transaction to the held factors and returns the reading that
    // the block must report for it.
    function automatic derating_reading_t apply_lookup(input logic [1:0] op, input value_t val);
        derating_reading_t r;
        int v;
        v = int'(val);
        r.ok = 1'b0;
        case (op)
            OP_VOLTAGE: begin
                held_voltage = interpolate(1'b0, v);
                r.ok = 1'b1;
            end
            OP_TEMPERATURE: begin
                held_temperature = interpolate(1'b1, v);
                r.ok = 1'b1;
            end
            OP_PROCESS: begin
                // The process register keeps its old factor when the corner is not one
                // of 1, 2 or 3.
                if (v >= 1 && v <= CORNER_PTS) begin
                    held_process = factor_t'(ppm_to_q20(longint'(CORNER_PPM[v - 1])));
                    r.ok = 1'b1;
                end
            end
            default: begin
                // The unused operation code changes nothing, and the block reports the
                // held factors with the flag cleared.
            end
        endcase
        r.voltage     = held_voltage;
        r.temperature = held_temperature;
        r.process     = held_process;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: back-pressure and checking
    // ------------------------------------------------------------------

    // The ready signal is drawn again on every clock edge. With recv_idle_pct at zero, the
    // receiver never stalls.
    always @(posedge aclk) begin
        m_ready <= aresetn ? ($urandom_range(99) >= recv_idle_pct) : 1'b0;
    end

    // This process samples at the rising edge, so it sees the values that the block
    // itself saw there. Every handshake on the m_ channel consumes one predicted reading.
    always @(posedge aclk) begin : check_results
        derating_reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                $error("result transaction with no lookup outstanding");
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                if (m_voltage_factor !== want.voltage) begin
                    $error("voltage_factor: expected %0d, got %0d",
                           want.voltage, m_voltage_factor);
                    mismatch_count++;
                end
                if (m_temperature_factor !== want.temperature) begin
                    $error("temperature_factor: expected %0d, got %0d",
                           want.temperature, m_temperature_factor);
                    mismatch_count++;
                end
                if (m_process_factor !== want.process) begin
                    $error("process_factor: expected %0d, got %0d",
                           want.process, m_process_factor);
                    mismatch_count++;
                end
                if (m_accepted !== want.ok) begin
                    $error("accepted: expected %0d, got %0d", want.ok, m_accepted);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Sends one lookup request. Before the request, valid may drop for a random number
    // of cycles. Valid is never lowered at the end of this task. When the next request
    // follows with no gap, valid therefore stays high across both transactions, since the
    // next request only drives it high again.
    task automatic send_request(input logic [1:0] op, input value_t val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= val;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_readings.push_back(apply_lookup(op, val));
    endtask

    // Draws one random request. Most requests fall in or near the tables' working
    // ranges, so that every segment and both extrapolations are reached. The rest are
    // exact breakpoints, process corners around the valid ones, the unused operation
    // code, and raw values that toggle every bit of both fields.
    task automatic send_random_request();
        int         sel;
        logic [1:0] op;
        int         v;
        sel = $urandom_range(99);
        if (sel < 30) begin
            op = OP_VOLTAGE;
            v  = $urandom_range(1400, 1000);
        end else if (sel < 58) begin
            op = OP_TEMPERATURE;
            v  = int'($urandom_range(2600, 0)) - 500;
        end else if (sel < 70) begin
            op = OP_PROCESS;
            v  = int'($urandom_range(5, 0)) - 1;
        end else if (sel < 80) begin
            if ($urandom_range(1)) begin
                op = OP_TEMPERATURE;
                v  = TEMP_LSB[$urandom_range(TEMP_PTS - 1)];
            end else begin
                op = OP_VOLTAGE;
                v  = VOLT_MV[$urandom_range(VOLT_PTS - 1)];
            end
        end else if (sel < 85) begin
            op = OP_UNUSED;
            v  = $urandom;
        end else begin
            op = 2'($urandom_range(3));
            v  = $urandom;
        end
        send_request(op, value_t'(v));
    endtask

    task automatic wait_until_drained();
        do
            @(posedge aclk);
        while (pending_readings.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // This test covers the breakpoints at both ends, one point inside a segment, values
    // just outside the table, and the full-scale values that clamp the factor at each
    // limit.
    task automatic test_voltage_table();
        send_request(OP_VOLTAGE, 13'sd1080);
        send_request(OP_VOLTAGE, 13'sd1320);
        send_request(OP_VOLTAGE, 13'sd1100);
        send_request(OP_VOLTAGE, 13'sd1000);
        send_request(OP_VOLTAGE, 13'sd1400);
        send_request(OP_VOLTAGE, -13'sd4096);
        send_request(OP_VOLTAGE, 13'sd4095);
    endtask

    task automatic test_temperature_table();
        send_request(OP_TEMPERATURE, -13'sd400);
        send_request(OP_TEMPERATURE, 13'sd0);
        send_request(OP_TEMPERATURE, 13'sd2000);
        send_request(OP_TEMPERATURE, 13'sd100);
        send_request(OP_TEMPERATURE, -13'sd500);
        send_request(OP_TEMPERATURE, 13'sd2100);
        send_request(OP_TEMPERATURE, -13'sd4096);
        send_request(OP_TEMPERATURE, 13'sd4095);
    endtask

    // This test sends all three valid corners. It then sends invalid corners, which must
    // leave the last valid corner's factor in place.
    task automatic test_process_corners();
        send_request(OP_PROCESS, 13'sd1);
        send_request(OP_PROCESS, 13'sd2);
        send_request(OP_PROCESS, 13'sd3);
        send_request(OP_PROCESS, 13'sd0);
        send_request(OP_PROCESS, 13'sd4);
        send_request(OP_PROCESS, -13'sd1);
    endtask

    task automatic test_unused_operation();
        send_request(OP_UNUSED, 13'sd4095);
        send_request(OP_UNUSED, -13'sd4096);
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
            send_random_request();
    endtask

    // In this test the sender stops after each burst and waits until the block has
    // returned every outstanding result. The next burst then starts from an idle block.
    task automatic test_pause_until_drained();
        send_idle_pct = 0;
        recv_idle_pct = 50;
        repeat (3) begin
            repeat (15)
                send_random_request();
            s_valid <= 1'b0;
            wait_until_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (7)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_voltage_table();
        test_temperature_table();
        test_process_corners();
        test_unused_operation();
        test_random_traffic(460, 38, 85);
        test_pause_until_drained();
        test_random_traffic(460, 85, 38);
        test_random_traffic(460, 0, 0);

        s_valid <= 1'b0;
        wait_until_drained();
        repeat (SETTLE_CYCLES)
            @(posedge aclk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // This is a watchdog. Its limit is far above the slowest legal run, so it fires only
    // when the handshake hangs or results stop arriving.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/pdi_pkg.sv
rtl/core/pdi_seg_sel.sv
rtl/core/pdi_interp.sv
rtl/core/pvt_derating_interpolator_top.sv
tb/tb_top.sv
